[src/block_cipher_128_key_256_encrypt_defines.svh]
// assertion macros for the kalyna-style encrypt block
// used by the top level only
`ifndef BLOCK_CIPHER_128_KEY_256_ENCRYPT_DEFINES_SVH
`define BLOCK_CIPHER_128_KEY_256_ENCRYPT_DEFINES_SVH
// implication checked every clock outside reset
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

[src/bc128_pkg.sv]
// package for the block cipher: sizes, state codes, s-boxes, mix row and gf arithmetic
// no dependencies
`default_nettype none
package bc128_pkg;
   localparam int ROUNDS    = 14;
   localparam int KEY_WORDS = 2 * (ROUNDS + 1);
   localparam int SLOT_W    = 5;
   localparam int ROUND_W   = $clog2(ROUNDS + 1);

   localparam logic FUNC_LOAD    = 1'b0;
   localparam logic FUNC_ENCRYPT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   typedef logic [7:0] sbox_type [256];

   localparam sbox_type SBOX0 = '{
8'ha8,8'h43,8'h5f,8'h06,8'h6b,8'h75,8'h6c,8'h59,8'h71,8'hdf,8'h87,8'h95,8'h17,8'hf0,8'hd8,8'h09,
8'h6d,8'hf3,8'h1d,8'hcb,8'hc9,8'h4d,8'h2c,8'haf,8'h79,8'he0,8'h97,8'hfd,8'h6f,8'h4b,8'h45,8'h39,
8'h3e,8'hdd,8'ha3,8'h4f,8'hb4,8'hb6,8'h9a,8'h0e,8'h1f,8'hbf,8'h15,8'he1,8'h49,8'hd2,8'h93,8'hc6,
8'h92,8'h72,8'h9e,8'h61,8'hd1,8'h63,8'hfa,8'hee,8'hf4,8'h19,8'hd5,8'had,8'h58,8'ha4,8'hbb,8'ha1,
8'hdc,8'hf2,8'h83,8'h37,8'h42,8'he4,8'h7a,8'h32,8'h9c,8'hcc,8'hab,8'h4a,8'h8f,8'h6e,8'h04,8'h27,
8'h2e,8'he7,8'he2,8'h5a,8'h96,8'h16,8'h23,8'h2b,8'hc2,8'h65,8'h66,8'h0f,8'hbc,8'ha9,8'h47,8'h41,
8'h34,8'h48,8'hfc,8'hb7,8'h6a,8'h88,8'ha5,8'h53,8'h86,8'hf9,8'h5b,8'hdb,8'h38,8'h7b,8'hc3,8'h1e,
8'h22,8'h33,8'h24,8'h28,8'h36,8'hc7,8'hb2,8'h3b,8'h8e,8'h77,8'hba,8'hf5,8'h14,8'h9f,8'h08,8'h55,
8'h9b,8'h4c,8'hfe,8'h60,8'h5c,8'hda,8'h18,8'h46,8'hcd,8'h7d,8'h21,8'hb0,8'h3f,8'h1b,8'h89,8'hff,
8'heb,8'h84,8'h69,8'h3a,8'h9d,8'hd7,8'hd3,8'h70,8'h67,8'h40,8'hb5,8'hde,8'h5d,8'h30,8'h91,8'hb1,
8'h78,8'h11,8'h01,8'he5,8'h00,8'h68,8'h98,8'ha0,8'hc5,8'h02,8'ha6,8'h74,8'h2d,8'h0b,8'ha2,8'h76,
8'hb3,8'hbe,8'hce,8'hbd,8'hae,8'he9,8'h8a,8'h31,8'h1c,8'hec,8'hf1,8'h99,8'h94,8'haa,8'hf6,8'h26,
8'h2f,8'hef,8'he8,8'h8c,8'h35,8'h03,8'hd4,8'h7f,8'hfb,8'h05,8'hc1,8'h5e,8'h90,8'h20,8'h3d,8'h82,
8'hf7,8'hea,8'h0a,8'h0d,8'h7e,8'hf8,8'h50,8'h1a,8'hc4,8'h07,8'h57,8'hb8,8'h3c,8'h62,8'he3,8'hc8,
8'hac,8'h52,8'h64,8'h10,8'hd0,8'hd9,8'h13,8'h0c,8'h12,8'h29,8'h51,8'hb9,8'hcf,8'hd6,8'h73,8'h8d,
8'h81,8'h54,8'hc0,8'hed,8'h4e,8'h44,8'ha7,8'h2a,8'h85,8'h25,8'he6,8'hca,8'h7c,8'h8b,8'h56,8'h80};
   localparam sbox_type SBOX1 = '{
8'hce,8'hbb,8'heb,8'h92,8'hea,8'hcb,8'h13,8'hc1,8'he9,8'h3a,8'hd6,8'hb2,8'hd2,8'h90,8'h17,8'hf8,
8'h42,8'h15,8'h56,8'hb4,8'h65,8'h1c,8'h88,8'h43,8'hc5,8'h5c,8'h36,8'hba,8'hf5,8'h57,8'h67,8'h8d,
8'h31,8'hf6,8'h64,8'h58,8'h9e,8'hf4,8'h22,8'haa,8'h75,8'h0f,8'h02,8'hb1,8'hdf,8'h6d,8'h73,8'h4d,
8'h7c,8'h26,8'h2e,8'hf7,8'h08,8'h5d,8'h44,8'h3e,8'h9f,8'h14,8'hc8,8'hae,8'h54,8'h10,8'hd8,8'hbc,
8'h1a,8'h6b,8'h69,8'hf3,8'hbd,8'h33,8'hab,8'hfa,8'hd1,8'h9b,8'h68,8'h4e,8'h16,8'h95,8'h91,8'hee,
8'h4c,8'h63,8'h8e,8'h5b,8'hcc,8'h3c,8'h19,8'ha1,8'h81,8'h49,8'h7b,8'hd9,8'h6f,8'h37,8'h60,8'hca,
8'he7,8'h2b,8'h48,8'hfd,8'h96,8'h45,8'hfc,8'h41,8'h12,8'h0d,8'h79,8'he5,8'h89,8'h8c,8'he3,8'h20,
8'h30,8'hdc,8'hb7,8'h6c,8'h4a,8'hb5,8'h3f,8'h97,8'hd4,8'h62,8'h2d,8'h06,8'ha4,8'ha5,8'h83,8'h5f,
8'h2a,8'hda,8'hc9,8'h00,8'h7e,8'ha2,8'h55,8'hbf,8'h11,8'hd5,8'h9c,8'hcf,8'h0e,8'h0a,8'h3d,8'h51,
8'h7d,8'h93,8'h1b,8'hfe,8'hc4,8'h47,8'h09,8'h86,8'h0b,8'h8f,8'h9d,8'h6a,8'h07,8'hb9,8'hb0,8'h98,
8'h18,8'h32,8'h71,8'h4b,8'hef,8'h3b,8'h70,8'ha0,8'he4,8'h40,8'hff,8'hc3,8'ha9,8'he6,8'h78,8'hf9,
8'h8b,8'h46,8'h80,8'h1e,8'h38,8'he1,8'hb8,8'ha8,8'he0,8'h0c,8'h23,8'h76,8'h1d,8'h25,8'h24,8'h05,
8'hf1,8'h6e,8'h94,8'h28,8'h9a,8'h84,8'he8,8'ha3,8'h4f,8'h77,8'hd3,8'h85,8'he2,8'h52,8'hf2,8'h82,
8'h50,8'h7a,8'h2f,8'h74,8'h53,8'hb3,8'h61,8'haf,8'h39,8'h35,8'hde,8'hcd,8'h1f,8'h99,8'hac,8'had,
8'h72,8'h2c,8'hdd,8'hd0,8'h87,8'hbe,8'h5e,8'ha6,8'hec,8'h04,8'hc6,8'h03,8'h34,8'hfb,8'hdb,8'h59,
8'hb6,8'hc2,8'h01,8'hf0,8'h5a,8'hed,8'ha7,8'h66,8'h21,8'h7f,8'h8a,8'h27,8'hc7,8'hc0,8'h29,8'hd7};
   localparam sbox_type SBOX2 = '{
8'h93,8'hd9,8'h9a,8'hb5,8'h98,8'h22,8'h45,8'hfc,8'hba,8'h6a,8'hdf,8'h02,8'h9f,8'hdc,8'h51,8'h59,
8'h4a,8'h17,8'h2b,8'hc2,8'h94,8'hf4,8'hbb,8'ha3,8'h62,8'he4,8'h71,8'hd4,8'hcd,8'h70,8'h16,8'he1,
8'h49,8'h3c,8'hc0,8'hd8,8'h5c,8'h9b,8'had,8'h85,8'h53,8'ha1,8'h7a,8'hc8,8'h2d,8'he0,8'hd1,8'h72,
8'ha6,8'h2c,8'hc4,8'he3,8'h76,8'h78,8'hb7,8'hb4,8'h09,8'h3b,8'h0e,8'h41,8'h4c,8'hde,8'hb2,8'h90,
8'h25,8'ha5,8'hd7,8'h03,8'h11,8'h00,8'hc3,8'h2e,8'h92,8'hef,8'h4e,8'h12,8'h9d,8'h7d,8'hcb,8'h35,
8'h10,8'hd5,8'h4f,8'h9e,8'h4d,8'ha9,8'h55,8'hc6,8'hd0,8'h7b,8'h18,8'h97,8'hd3,8'h36,8'he6,8'h48,
8'h56,8'h81,8'h8f,8'h77,8'hcc,8'h9c,8'hb9,8'he2,8'hac,8'hb8,8'h2f,8'h15,8'ha4,8'h7c,8'hda,8'h38,
8'h1e,8'h0b,8'h05,8'hd6,8'h14,8'h6e,8'h6c,8'h7e,8'h66,8'hfd,8'hb1,8'he5,8'h60,8'haf,8'h5e,8'h33,
8'h87,8'hc9,8'hf0,8'h5d,8'h6d,8'h3f,8'h88,8'h8d,8'hc7,8'hf7,8'h1d,8'he9,8'hec,8'hed,8'h80,8'h29,
8'h27,8'hcf,8'h99,8'ha8,8'h50,8'h0f,8'h37,8'h24,8'h28,8'h30,8'h95,8'hd2,8'h3e,8'h5b,8'h40,8'h83,
8'hb3,8'h69,8'h57,8'h1f,8'h07,8'h1c,8'h8a,8'hbc,8'h20,8'heb,8'hce,8'h8e,8'hab,8'hee,8'h31,8'ha2,
8'h73,8'hf9,8'hca,8'h3a,8'h1a,8'hfb,8'h0d,8'hc1,8'hfe,8'hfa,8'hf2,8'h6f,8'hbd,8'h96,8'hdd,8'h43,
8'h52,8'hb6,8'h08,8'hf3,8'hae,8'hbe,8'h19,8'h89,8'h32,8'h26,8'hb0,8'hea,8'h4b,8'h64,8'h84,8'h82,
8'h6b,8'hf5,8'h79,8'hbf,8'h01,8'h5f,8'h75,8'h63,8'h1b,8'h23,8'h3d,8'h68,8'h2a,8'h65,8'he8,8'h91,
8'hf6,8'hff,8'h13,8'h58,8'hf1,8'h47,8'h0a,8'h7f,8'hc5,8'ha7,8'he7,8'h61,8'h5a,8'h06,8'h46,8'h44,
8'h42,8'h04,8'ha0,8'hdb,8'h39,8'h86,8'h54,8'haa,8'h8c,8'h34,8'h21,8'h8b,8'hf8,8'h0c,8'h74,8'h67};
   localparam sbox_type SBOX3 = '{
8'h68,8'h8d,8'hca,8'h4d,8'h73,8'h4b,8'h4e,8'h2a,8'hd4,8'h52,8'h26,8'hb3,8'h54,8'h1e,8'h19,8'h1f,
8'h22,8'h03,8'h46,8'h3d,8'h2d,8'h4a,8'h53,8'h83,8'h13,8'h8a,8'hb7,8'hd5,8'h25,8'h79,8'hf5,8'hbd,
8'h58,8'h2f,8'h0d,8'h02,8'hed,8'h51,8'h9e,8'h11,8'hf2,8'h3e,8'h55,8'h5e,8'hd1,8'h16,8'h3c,8'h66,
8'h70,8'h5d,8'hf3,8'h45,8'h40,8'hcc,8'he8,8'h94,8'h56,8'h08,8'hce,8'h1a,8'h3a,8'hd2,8'he1,8'hdf,
8'hb5,8'h38,8'h6e,8'h0e,8'he5,8'hf4,8'hf9,8'h86,8'he9,8'h4f,8'hd6,8'h85,8'h23,8'hcf,8'h32,8'h99,
8'h31,8'h14,8'hae,8'hee,8'hc8,8'h48,8'hd3,8'h30,8'ha1,8'h92,8'h41,8'hb1,8'h18,8'hc4,8'h2c,8'h71,
8'h72,8'h44,8'h15,8'hfd,8'h37,8'hbe,8'h5f,8'haa,8'h9b,8'h88,8'hd8,8'hab,8'h89,8'h9c,8'hfa,8'h60,
8'hea,8'hbc,8'h62,8'h0c,8'h24,8'ha6,8'ha8,8'hec,8'h67,8'h20,8'hdb,8'h7c,8'h28,8'hdd,8'hac,8'h5b,
8'h34,8'h7e,8'h10,8'hf1,8'h7b,8'h8f,8'h63,8'ha0,8'h05,8'h9a,8'h43,8'h77,8'h21,8'hbf,8'h27,8'h09,
8'hc3,8'h9f,8'hb6,8'hd7,8'h29,8'hc2,8'heb,8'hc0,8'ha4,8'h8b,8'h8c,8'h1d,8'hfb,8'hff,8'hc1,8'hb2,
8'h97,8'h2e,8'hf8,8'h65,8'hf6,8'h75,8'h07,8'h04,8'h49,8'h33,8'he4,8'hd9,8'hb9,8'hd0,8'h42,8'hc7,
8'h6c,8'h90,8'h00,8'h8e,8'h6f,8'h50,8'h01,8'hc5,8'hda,8'h47,8'h3f,8'hcd,8'h69,8'ha2,8'he2,8'h7a,
8'ha7,8'hc6,8'h93,8'h0f,8'h0a,8'h06,8'he6,8'h2b,8'h96,8'ha3,8'h1c,8'haf,8'h6a,8'h12,8'h84,8'h39,
8'he7,8'hb0,8'h82,8'hf7,8'hfe,8'h9d,8'h87,8'h5c,8'h81,8'h35,8'hde,8'hb4,8'ha5,8'hfc,8'h80,8'hef,
8'hcb,8'hbb,8'h6b,8'h76,8'hba,8'h5a,8'h7d,8'h78,8'h0b,8'h95,8'he3,8'had,8'h74,8'h98,8'h3b,8'h36,
8'h64,8'h6d,8'hdc,8'hf0,8'h59,8'ha9,8'h4c,8'h17,8'h7f,8'h91,8'hb8,8'hc9,8'h57,8'h1b,8'he0,8'h61};

   typedef logic [7:0] mix_row_type [8];
   localparam mix_row_type MIX_ROW = '{8'h01, 8'h01, 8'h05, 8'h01,
                                       8'h08, 8'h06, 8'h07, 8'h04};

   // multiply by x in gf(2^8) mod 0x11d
   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1d : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] x;
      logic [7:0] r;
      x = a;
      r = '0;
      for (int k = 0; k < 8; k++) begin
         if (b[k]) r = r ^ x;
         x = xtime(x);
      end
      gf_mul = r;
   endfunction

   function automatic logic [7:0] sbox(input logic [1:0] sel, input logic [7:0] v);
      logic [7:0] res;
      res = '0;
      case (sel)
         2'd0: res = SBOX0[v];
         2'd1: res = SBOX1[v];
         2'd2: res = SBOX2[v];
         2'd3: res = SBOX3[v];
         default: res = '0;
      endcase
      sbox = res;
   endfunction
endpackage
`default_nettype wire

[src/bc128_round.sv]
// one cipher round: s-boxes, row shift and mds mix on the two-column state
// depends on bc128_pkg for tables and gf arithmetic
`default_nettype none
module bc128_round (
   input  wire  logic [63:0] col0,
   input  wire  logic [63:0] col1,
   output logic [63:0] mix0,
   output logic [63:0] mix1
);
   import bc128_pkg::*;

   logic [7:0] t0 [8];
   logic [7:0] t1 [8];

   always_comb begin
      for (int b = 0; b < 8; b++) begin
         // upper four bytes come from the other column
         if (b < 4) begin
            t0[b] = sbox(2'(b), col0[8*b +: 8]);
            t1[b] = sbox(2'(b), col1[8*b +: 8]);
         end else begin
            t0[b] = sbox(2'(b), col1[8*b +: 8]);
            t1[b] = sbox(2'(b), col0[8*b +: 8]);
         end
      end
      for (int r = 0; r < 8; r++) begin
         mix0[8*r +: 8] = '0;
         mix1[8*r +: 8] = '0;
         for (int b = 0; b < 8; b++) begin
            mix0[8*r +: 8] = mix0[8*r +: 8] ^ gf_mul(t0[b], MIX_ROW[(b - r) & 7]);
            mix1[8*r +: 8] = mix1[8*r +: 8] ^ gf_mul(t1[b], MIX_ROW[(b - r) & 7]);
         end
      end
   end
endmodule
`default_nettype wire

[src/block_cipher_128_key_256_encrypt.sv]
// 128-bit block encrypt with 256-bit key schedule loaded as round-key words
// depends on bc128_pkg, bc128_round and the assertion macro header
//
// usage:
//   req_ channel carries one transaction: func=0 writes key_word into
//   round-key slot key_slot (slots beyond 29 are dropped), func=1 encrypts
//   plain_low/plain_high with the stored keys. only encrypts make a
//   rsp_ transaction with cipher_low/cipher_high.
//   an encrypt works in steps: the key-0 addition in the accept cycle's
//   follow-on step, then one round per cycle through a single shared
//   round unit, one key pair read per step from the round-key store. the
//   result sits in an output register until rsp_ready; req_ready is low
//   while an encrypt runs or its result waits.
//   reset clears the sequencer and the output valid; the key store keeps
//   no reset and must be loaded before use.
`default_nettype none
`include "block_cipher_128_key_256_encrypt_defines.svh"
module block_cipher_128_key_256_encrypt (
   input  wire  logic        clock,
   input  wire  logic        reset,
   input  wire  logic        req_valid,
   output logic              req_ready,
   input  wire  logic        req_func,
   input  wire  logic [4:0]  req_key_slot,
   input  wire  logic [63:0] req_key_word,
   input  wire  logic [63:0] req_plain_low,
   input  wire  logic [63:0] req_plain_high,
   output logic              rsp_valid,
   input  wire  logic        rsp_ready,
   output logic [63:0]       rsp_cipher_low,
   output logic [63:0]       rsp_cipher_high
);
   import bc128_pkg::*;

   // key store split into even and odd halves so one pair reads per cycle
   logic [63:0] key_lo_mem [ROUNDS + 1];
   logic [63:0] key_hi_mem [ROUNDS + 1];

   state_type state_ff, state_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   logic [63:0] s0_ff, s0_in, s1_ff, s1_in;
   logic [63:0] plo_ff, phi_ff;
   logic [63:0] k0_ff, k1_ff;
   logic [ROUND_W-1:0] rd_idx;
   logic [63:0] mix0, mix1;
   logic accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_cipher_low  = s0_ff;
   assign rsp_cipher_high = s1_ff;
   assign accept = req_valid && req_ready;

   bc128_round u_round (.col0(s0_ff), .col1(s1_ff), .mix0(mix0), .mix1(mix1));

   // key read index: pair 0 on accept, then the pair for the next round
   always_comb begin
      if (state_ff == ST_IDLE) rd_idx = '0;
      else                     rd_idx = ROUND_W'(round_ff + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (accept && req_func == FUNC_LOAD && req_key_slot < SLOT_W'(KEY_WORDS)) begin
         if (req_key_slot[0]) key_hi_mem[req_key_slot[4:1]] <= req_key_word;
         else                 key_lo_mem[req_key_slot[4:1]] <= req_key_word;
      end
      if (rd_idx <= ROUND_W'(ROUNDS)) begin
         k0_ff <= key_lo_mem[rd_idx];
         k1_ff <= key_hi_mem[rd_idx];
      end
   end

   // round_ff = 0: add key 0 to plaintext; 1..ROUNDS: run that round
   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      s0_in = s0_ff;
      s1_in = s1_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_func == FUNC_ENCRYPT) begin
               state_in = ST_RUN;
               round_in = '0;
            end
         end
         ST_RUN: begin
            if (round_ff == '0) begin
               s0_in = plo_ff + k0_ff;
               s1_in = phi_ff + k1_ff;
            end else if (round_ff == ROUND_W'(ROUNDS)) begin
               s0_in = mix0 + k0_ff;
               s1_in = mix1 + k1_ff;
            end else begin
               s0_in = mix0 ^ k0_ff;
               s1_in = mix1 ^ k1_ff;
            end
            if (round_ff == ROUND_W'(ROUNDS)) state_in = ST_DONE;
            else round_in = ROUND_W'(round_ff + 1'b1);
         end
         ST_DONE: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         round_ff <= '0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
      end
      s0_ff <= s0_in;
      s1_ff <= s1_in;
      if (accept) begin
         plo_ff <= req_plain_low;
         phi_ff <= req_plain_high;
      end
   end

   `CHK_IMPL(a_ready_excl, clock, reset, rsp_valid, !req_ready, "ready while result pending")
   `CHK_NEXT(a_enc_starts, clock, reset, accept && req_func == FUNC_ENCRYPT,
             state_ff == ST_RUN && round_ff == '0, "encrypt did not start")
   `CHK_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready,
             rsp_valid && $stable(rsp_cipher_low), "result changed while stalled")
endmodule
`default_nettype wire
